[src/udprx_pkg.sv]
// Package: types, constants and status codes for the UDP receive block.
package udprx_pkg;

    localparam int BINDING_SLOTS_DEF = 16;
    localparam logic [15:0] SAT_MAX = 16'hFFFF;
    localparam logic [15:0] HDR_LEN = 16'd8;
    localparam logic [15:0] PROTO_UDP = 16'd17;

    typedef enum logic [1:0] {
        FN_BYTE   = 2'd0,
        FN_BIND   = 2'd1,
        FN_UNBIND = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_DELIVERED = 3'd0,
        ST_MALFORMED = 3'd1,
        ST_BAD_CSUM  = 3'd2,
        ST_NO_LISTEN = 3'd3,
        ST_BOUND     = 3'd4,
        ST_REFUSED   = 3'd5,
        ST_UNBOUND   = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PSEUDO,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  data_byte;
        logic        last;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] port;
        logic [7:0]  listener_tag;
        logic        has_original_packet;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] payload_length;
        logic [7:0]  matched_tag;
        logic        send_unreachable;
    } t_out;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

[src/udprx_ram.sv]
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module udprx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[src/udprx_seg.sv]
// Segment byte parser: header capture, saturating count, running checksum.
module udprx_seg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    input  logic        i_clear,
    output logic [63:0] o_hdr,
    output logic [15:0] o_count,
    output logic [15:0] o_sum,
    output logic [7:0]  o_pend
);
    import udprx_pkg::*;

    logic [63:0] r_hdr, n_hdr;
    logic [15:0] r_cnt, r_sum, n_sum;
    logic [7:0]  r_pend, n_pend;
    logic        in_range;

    always_comb begin
        n_hdr = r_hdr;
        if (r_cnt < HDR_LEN) begin
            n_hdr = {r_hdr[55:0], i_byte};
        end
        in_range = (r_cnt < HDR_LEN) || (r_cnt < n_hdr[31:16]);
        n_pend = r_pend;
        n_sum = r_sum;
        if (in_range) begin
            if (!r_cnt[0]) begin
                n_pend = i_byte;
            end else begin
                n_sum = oc_add(r_sum, {r_pend, i_byte});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_hdr <= '0;
            r_cnt <= '0;
            r_sum <= '0;
            r_pend <= '0;
        end else if (i_en) begin
            r_hdr <= n_hdr;
            r_sum <= n_sum;
            r_pend <= n_pend;
            if (r_cnt != SAT_MAX) begin
                r_cnt <= r_cnt + 16'd1;
            end
        end
    end

    assign o_hdr = r_hdr;
    assign o_count = r_cnt;
    assign o_sum = r_sum;
    assign o_pend = r_pend;
endmodule

[src/udp_receive_validate_and_demux.sv]
// UDP receive validation and port demultiplexing, top level.
// Segment byte: taken while idle, no result unless last. Bind, unbind: memory scan, result.
// Last byte: length check, then pseudo-header checksum if the field is nonzero, then scan
// and result; malformed or bad checksum ends early. Next request taken once the result is
// accepted. Synchronous active-low reset clears control state; the binding memory is then
// swept clear, BINDING_SLOTS entries rounded up to a power of two, taking no request.
module udp_receive_validate_and_demux #(
    parameter int BINDING_SLOTS = udprx_pkg::BINDING_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  udprx_pkg::t_in     i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output udprx_pkg::t_out    o_data,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata
);
    import udprx_pkg::*;

    localparam int AW = (BINDING_SLOTS > 1) ? $clog2(BINDING_SLOTS) : 1;
    localparam int RD = 1 << AW;
    localparam logic [AW:0] NSLOT = (AW + 1)'(BINDING_SLOTS);

    t_state r_st, n_st;
    logic [31:0] r_lip;
    t_in  r_req;
    t_out r_out, n_out;
    logic [AW:0] r_idx, n_idx;
    logic        r_rv, n_rv;
    logic [AW:0] r_free, n_free;
    logic        r_hasfree, n_hasfree;
    logic        r_hit, n_hit;
    logic [AW-1:0] r_hidx, n_hidx;
    logic [7:0]  r_htag, n_htag;
    logic [15:0] r_s, n_s;
    logic [2:0]  r_ph, n_ph;
    logic        r_sweep;
    logic [AW:0] r_sw;
    logic [15:0] r_ulen, r_len;
    logic [63:0] r_hf;

    logic acc, seg_en, seg_clr;
    logic [63:0] hdr;
    logic [15:0] cnt, sum;
    logic [7:0]  pend;
    logic        we;
    logic [AW-1:0] waddr;
    logic [24:0] wdata, rdata;
    logic [15:0] key;

    assign o_ready = (r_st == S_IDLE) && !r_sweep;
    assign acc = i_valid && o_ready;
    assign seg_en = acc && (t_func'(i_data.func) == FN_BYTE);
    assign o_valid = (r_st == S_OUT);
    assign o_data = r_out;

    udprx_seg u_seg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(seg_en), .i_byte(i_data.data_byte),
        .i_clear(seg_clr), .o_hdr(hdr), .o_count(cnt), .o_sum(sum), .o_pend(pend)
    );

    udprx_ram #(.WIDTH(25), .DEPTH(RD)) u_tab (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(n_idx[AW-1:0]), .o_rdata(rdata)
    );

    assign key = (t_func'(r_req.func) == FN_BYTE) ? r_hf[47:32] : r_req.port;

    always_comb begin
        n_st = r_st;
        n_out = r_out;
        n_idx = r_idx;
        n_rv = 1'b0;
        n_free = r_free;
        n_hasfree = r_hasfree;
        n_hit = r_hit;
        n_hidx = r_hidx;
        n_htag = r_htag;
        n_s = r_s;
        n_ph = r_ph;
        seg_clr = 1'b0;
        we = 1'b0;
        waddr = r_sw[AW-1:0];
        wdata = '0;
        case (r_st)
            S_IDLE: begin
                if (acc) begin
                    n_idx = '0;
                    n_hit = 1'b0;
                    n_hasfree = 1'b0;
                    n_out = '0;
                    case (t_func'(i_data.func))
                        FN_BIND, FN_UNBIND: begin
                            n_st = S_SCAN;
                            n_rv = 1'b1;
                        end
                        FN_BYTE: begin
                            if (i_data.last) begin
                                n_st = S_FIN;
                            end
                        end
                        default: n_st = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_rv) begin
                    if (rdata[24] && rdata[23:8] == key && !r_hit) begin
                        n_hit = 1'b1;
                        n_hidx = r_idx[AW-1:0];
                        n_htag = rdata[7:0];
                    end
                    if (!rdata[24] && !r_hasfree) begin
                        n_hasfree = 1'b1;
                        n_free = r_idx;
                    end
                end
                if (r_rv && r_idx + 1'b1 < NSLOT) begin
                    n_idx = r_idx + 1'b1;
                    n_rv = 1'b1;
                end else if (r_rv) begin
                    n_st = S_OUT;
                    case (t_func'(r_req.func))
                        FN_BIND: begin
                            if (r_req.port == 16'd0 || n_hit || !n_hasfree) begin
                                n_out.status = ST_REFUSED;
                            end else begin
                                n_out.status = ST_BOUND;
                                n_out.slot = 4'(n_free);
                                we = 1'b1;
                                waddr = n_free[AW-1:0];
                                wdata = {1'b1, r_req.port, r_req.listener_tag};
                            end
                        end
                        FN_UNBIND: begin
                            n_out.status = ST_UNBOUND;
                            if (n_hit) begin
                                n_out.slot = 4'(n_hidx);
                                we = 1'b1;
                                waddr = n_hidx;
                            end
                        end
                        default: begin
                            n_out.source_port = r_hf[63:48];
                            n_out.dest_port = r_hf[47:32];
                            n_out.payload_length = r_ulen - HDR_LEN;
                            if (n_hit) begin
                                n_out.status = ST_DELIVERED;
                                n_out.slot = 4'(n_hidx);
                                n_out.matched_tag = n_htag;
                            end else begin
                                n_out.status = ST_NO_LISTEN;
                                n_out.send_unreachable = (r_req.dst_ip == r_lip)
                                    && r_req.has_original_packet;
                            end
                        end
                    endcase
                end
            end
            S_FIN: begin
                seg_clr = 1'b1;
                if (r_len < HDR_LEN || r_ulen < HDR_LEN || r_ulen > r_len) begin
                    n_out.status = ST_MALFORMED;
                    n_st = S_OUT;
                end else if (r_hf[15:0] != 16'd0) begin
                    n_s = r_ulen[0] ? oc_add(sum, {pend, 8'd0}) : sum;
                    n_ph = 3'd0;
                    n_st = S_PSEUDO;
                end else begin
                    n_st = S_SCAN;
                    n_rv = 1'b1;
                end
            end
            S_PSEUDO: begin
                case (r_ph)
                    3'd0: n_s = oc_add(r_s, r_req.src_ip[31:16]);
                    3'd1: n_s = oc_add(r_s, r_req.src_ip[15:0]);
                    3'd2: n_s = oc_add(r_s, r_req.dst_ip[31:16]);
                    3'd3: n_s = oc_add(r_s, r_req.dst_ip[15:0]);
                    3'd4: n_s = oc_add(r_s, PROTO_UDP);
                    3'd5: n_s = oc_add(r_s, r_ulen);
                    default: n_s = r_s;
                endcase
                n_ph = r_ph + 3'd1;
                if (r_ph == 3'd6) begin
                    if (r_s != SAT_MAX) begin
                        n_out.status = ST_BAD_CSUM;
                        n_out.source_port = r_hf[63:48];
                        n_out.dest_port = r_hf[47:32];
                        n_out.payload_length = r_ulen - HDR_LEN;
                        n_st = S_OUT;
                    end else begin
                        n_st = S_SCAN;
                        n_rv = 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
        if (r_sweep) begin
            we = 1'b1;
            waddr = r_sw[AW-1:0];
            wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_lip <= '0;
            r_rv <= 1'b0;
            r_sweep <= 1'b1;
            r_sw <= '0;
        end else begin
            r_st <= n_st;
            r_rv <= n_rv;
            if (i_cfg_we) begin
                r_lip <= i_cfg_wdata;
            end
            if (r_sweep) begin
                r_sw <= r_sw + 1'b1;
                if (r_sw + 1'b1 >= (AW + 1)'(RD)) begin
                    r_sweep <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_idx <= n_idx;
        r_free <= n_free;
        r_hasfree <= n_hasfree;
        r_hit <= n_hit;
        r_hidx <= n_hidx;
        r_htag <= n_htag;
        r_s <= n_s;
        r_ph <= n_ph;
        if (acc) begin
            r_req <= i_data;
        end
        if (seg_en) begin
            r_hf <= (cnt < HDR_LEN) ? {hdr[55:0], i_data.data_byte} : hdr;
            r_ulen <= (cnt < HDR_LEN) ? hdr[23:8] : hdr[31:16];
            r_len <= (cnt != SAT_MAX) ? cnt + 16'd1 : cnt;
        end
    end
endmodule
